// ===== rtl/core/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int WORD_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WORD_W-1:0]   word_type;

   localparam kind_type KIND_PUSH_FRONT = 3'd0;
   localparam kind_type KIND_PUSH_BACK  = 3'd1;
   localparam kind_type KIND_POP_FRONT  = 3'd2;
   localparam kind_type KIND_POP_BACK   = 3'd3;
   localparam kind_type KIND_LIST       = 3'd4;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_UNDERFLOW = 2'd1;
   localparam status_type STATUS_OVERFLOW  = 2'd2;
   localparam status_type STATUS_EMPTY     = 2'd3;

   // what a cell loads at the next edge
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD_VALUE,
      CELL_LOAD_LEFT,
      CELL_LOAD_RIGHT,
      CELL_LOAD_FRONT
   } cell_op_type;

endpackage

// ===== rtl/core/double_ended_queue_core.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words, held in a row of cells.
// Outside a list the front entry is in cell 0, the back entry in cell count-1.
// Request channel req_*: tuser carries the operation (push front, push back,
// pop front, pop back, list), tdata the word to push.
// Response channel rsp_*: tdata the popped or listed word (zero otherwise),
// tuser the status (ok, underflow, overflow, empty list), tlast marks the
// final response of a request.
// Push and pop: one request per cycle is accepted while the output is free,
// and its response is in the output register in the cycle after acceptance.
// A push front shifts the whole row by one cell, a pop front shifts it back.
// A list gives one response per stored entry: the occupied cells rotate
// toward cell 0 once per cycle while the output is free, so the row is back
// in order when the list ends. No request is taken while a list is running.
// Requests with an unused operation code are accepted and give no response.
// Reset empties the queue and drops any pending response; the cell contents
// are not cleared. When the receiver stalls, the response register holds and
// req_tready falls until the response is taken.
module double_ended_queue_core #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // [31:0] value
   input  logic [2:0]             req_tuser,  // [2:0] kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // [31:0] word
   output logic [1:0]             rsp_tuser,  // [1:0] status
   output logic                   rsp_tlast
);
   import dq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          list_busy_ff, list_busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_word_ff, rsp_word_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   word_type      cell_word [DEPTH];
   cell_op_type   cell_op [DEPTH];

   logic          out_free;
   logic          accept;
   logic          rotate;
   logic          full;
   logic          empty;
   kind_type      kind;
   logic [CW-1:0] back_sum;
   logic [IW-1:0] back_idx;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_free && !list_busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign rotate     = list_busy_ff && out_free;
   assign kind       = req_tuser;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign back_sum   = count_ff - CW'(1);
   assign back_idx   = back_sum[IW-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_word;
      word_type right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_word[i+1];
      end

      always_comb begin
         cell_op[i] = CELL_HOLD;
         if (rotate) begin
            // occupied cells rotate toward the front, the front wraps to the back
            if (CW'(i) == back_sum) begin
               cell_op[i] = CELL_LOAD_FRONT;
            end else if (CW'(i) < back_sum) begin
               cell_op[i] = CELL_LOAD_RIGHT;
            end
         end else if (accept) begin
            case (kind)
               KIND_PUSH_FRONT: begin
                  if (!full) begin
                     cell_op[i] = (i == 0) ? CELL_LOAD_VALUE : CELL_LOAD_LEFT;
                  end
               end
               KIND_PUSH_BACK: begin
                  if (!full && count_ff == CW'(i)) begin
                     cell_op[i] = CELL_LOAD_VALUE;
                  end
               end
               KIND_POP_FRONT: begin
                  if (!empty) begin
                     cell_op[i] = CELL_LOAD_RIGHT;
                  end
               end
               default: cell_op[i] = CELL_HOLD;
            endcase
         end
      end

      dq_cell u_cell (
         .clock    (clock),
         .op       (cell_op[i]),
         .value_in (req_tdata),
         .left_in  (left_word),
         .right_in (right_word),
         .front_in (cell_word[0]),
         .word_out (cell_word[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      remain_in     = remain_ff;
      list_busy_in  = list_busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (rotate) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = cell_word[0];
         rsp_status_in = STATUS_OK;
         rsp_last_in   = (remain_ff == CW'(1));
         remain_in     = remain_ff - CW'(1);
         if (remain_ff == CW'(1)) begin
            list_busy_in = 1'b0;
         end
      end else if (accept) begin
         unique case (kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = full ? STATUS_OVERFLOW : STATUS_OK;
               if (!full) begin
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = empty ? STATUS_UNDERFLOW : STATUS_OK;
               if (empty) begin
                  rsp_word_in = '0;
               end else begin
                  rsp_word_in = (kind == KIND_POP_FRONT) ? cell_word[0]
                                                         : cell_word[back_idx];
                  count_in    = count_ff - CW'(1);
               end
            end
            KIND_LIST: begin
               if (empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = '0;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_last_in   = 1'b1;
               end else begin
                  list_busy_in = 1'b1;
                  remain_in    = count_ff;
               end
            end
            default: begin
               // unused operation codes: no response, no change
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remain_ff    <= '0;
         list_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         list_busy_ff <= list_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/dq_cell.sv =====
`timescale 1ns / 1ps

module dq_cell (
   input  logic                clock,
   input  dq_pkg::cell_op_type op,
   input  dq_pkg::word_type    value_in,
   input  dq_pkg::word_type    left_in,
   input  dq_pkg::word_type    right_in,
   input  dq_pkg::word_type    front_in,
   output dq_pkg::word_type    word_out
);
   import dq_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      unique case (op)
         CELL_LOAD_VALUE: word_in = value_in;
         CELL_LOAD_LEFT:  word_in = left_in;
         CELL_LOAD_RIGHT: word_in = right_in;
         CELL_LOAD_FRONT: word_in = front_in;
         default:         word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ===== tb/double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
   import dq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 380;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;

   typedef struct {
      kind_type kind;
      word_type value;
      bit       wait_idle;
   } request_type;

   typedef struct {
      word_type   word;
      status_type status;
      logic       last;
   } response_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [2:0] req_tuser = '0;    // [2:0] kind
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] word
   logic [1:0] rsp_tuser;         // [1:0] status
   logic       rsp_tlast;

   double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   request_type  pending_requests[$];
   response_type expected_responses[$];

   // shadow deque: circular buffer, front position and fill level
   word_type deque_words [DEPTH];
   int       deque_front = 0;
   int       deque_count = 0;

   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_overflow = 0;
   int n_underflow = 0;
   int n_list = 0;
   int n_ignored = 0;
   int n_input_stall = 0;
   int cycle_count = 0;

   // planning state used while the stimulus is built
   int planned_valid = 0;
   int plan_count = 0;
   bit pause_next = 1'b0;

   task automatic expect_response(input word_type word, input status_type status,
                                  input logic last);
      response_type r;
      r.word = word;
      r.status = status;
      r.last = last;
      expected_responses.push_back(r);
   endtask

   task automatic apply_request(input kind_type kind, input word_type value);
      int pos;
      case (kind) inside
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (deque_count >= DEPTH) begin
               n_overflow++;
               expect_response('0, STATUS_OVERFLOW, 1'b1);
            end else begin
               if (kind == KIND_PUSH_FRONT) begin
                  deque_front = (deque_front + DEPTH - 1) % DEPTH;
                  pos = deque_front;
               end else begin
                  pos = (deque_front + deque_count) % DEPTH;
               end
               deque_words[pos] = value;
               deque_count++;
               expect_response('0, STATUS_OK, 1'b1);
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (deque_count == 0) begin
               n_underflow++;
               expect_response('0, STATUS_UNDERFLOW, 1'b1);
            end else begin
               if (kind == KIND_POP_FRONT) begin
                  pos = deque_front;
                  deque_front = (deque_front + 1) % DEPTH;
               end else begin
                  pos = (deque_front + deque_count - 1) % DEPTH;
               end
               deque_count--;
               expect_response(deque_words[pos], STATUS_OK, 1'b1);
            end
         end
         KIND_LIST: begin
            n_list++;
            if (deque_count == 0) begin
               expect_response('0, STATUS_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < deque_count; i++) begin
                  expect_response(deque_words[(deque_front + i) % DEPTH], STATUS_OK,
                                  (i == deque_count - 1));
               end
            end
         end
         default: n_ignored++;
      endcase
   endtask

   task automatic plan(input kind_type kind, input word_type value);
      request_type q;
      q.kind = kind;
      q.value = value;
      q.wait_idle = pause_next;
      pause_next = 1'b0;
      pending_requests.push_back(q);
      case (kind) inside
         KIND_PUSH_FRONT, KIND_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
         KIND_POP_FRONT, KIND_POP_BACK:   if (plan_count > 0) plan_count--;
         default: ;
      endcase
      if (kind <= KIND_LIST) planned_valid++;
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic kind_type push_side();
      return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
   endfunction

   function automatic kind_type pop_side();
      return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
   endfunction

   // sender: bursts of random length separated by random gaps
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      request_type next_req;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && !req_tready) n_input_stall++;
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].wait_idle && expected_responses.size() > 0)) begin
               next_req = pending_requests.pop_front();
               next_valid = 1'b1;
               req_tuser <= next_req.kind;
               req_tdata <= next_req.value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // receiver: stall pattern rotates with its own cycle count, plus long hold-offs
   int  rx_cycle = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left == 0 &&
             ((!long_hold_done && n_accepted >= 40) || $urandom_range(0, 1499) == 0)) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_cycle[8:7])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= ($urandom_range(0, 9) < 7);
               2'd2: rsp_tready <= (rx_cycle[1:0] != 2'd0);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: word %h status %0d last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = expected_responses.pop_front();
            n_checked++;
            if (rsp_tdata !== want.word) begin
               errors++;
               $display("%0t: word mismatch: expected %h, actual %h",
                        $time, want.word, rsp_tdata);
            end
            if (rsp_tuser !== want.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, expected_responses.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      // empty deque corners
      plan(KIND_POP_FRONT, 32'h1234_5678);
      plan(KIND_POP_BACK, 32'hffff_ffff);
      plan(KIND_LIST, '0);
      // extremes from both ends
      plan(KIND_PUSH_BACK, 32'h8000_0000);
      plan(KIND_PUSH_FRONT, 32'h7fff_ffff);
      plan(KIND_PUSH_BACK, 32'hffff_ffff);
      plan(KIND_PUSH_FRONT, 32'h0000_0000);
      plan(KIND_LIST, 32'hdead_beef);
      // unused operation codes are dropped
      plan(kind_type'(5), $urandom());
      plan(kind_type'(6), 32'h0000_0000);
      plan(kind_type'(7), 32'hffff_ffff);
      plan(KIND_POP_FRONT, '0);
      plan(KIND_POP_BACK, '0);
      plan(KIND_LIST, '0);
      plan(KIND_POP_BACK, '0);
      plan(KIND_POP_FRONT, '0);
      plan(KIND_POP_BACK, '0);
      plan(KIND_PUSH_FRONT, 32'h5555_5555);
      plan(KIND_POP_BACK, '0);
      plan(KIND_PUSH_BACK, 32'haaaa_aaaa);
      plan(KIND_POP_FRONT, '0);
      plan(KIND_LIST, '0);
      pause_next = 1'b1;

      while (planned_valid < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0: begin
               // fill to the top, then overflow
               while (plan_count < DEPTH) plan(push_side(), random_word());
               repeat ($urandom_range(1, 3)) plan(push_side(), random_word());
               plan(KIND_LIST, $urandom());
            end
            1: begin
               // drain to empty, then underflow
               while (plan_count > 0) plan(pop_side(), $urandom());
               repeat ($urandom_range(1, 2)) plan(pop_side(), $urandom());
               plan(KIND_LIST, $urandom());
            end
            2: pause_next = 1'b1;
            default: begin
               repeat ($urandom_range(5, 25)) begin
                  int r;
                  r = $urandom_range(0, 99);
                  if (r < 40) plan(push_side(), random_word());
                  else if (r < 75) plan(pop_side(), $urandom());
                  else if (r < 92) plan(KIND_LIST, $urandom());
                  else plan(kind_type'($urandom_range(5, 7)), $urandom());
               end
            end
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("checked %0d result items from %0d requests: %0d lists,",
               n_checked, n_accepted, n_list);
      $display("%0d overflows, %0d underflows, %0d unused codes dropped, %0d input stalls",
               n_overflow, n_underflow, n_ignored, n_input_stall);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue_core.sv
tb/double_ended_queue_core_tb.sv
